// ===== design/smalu_pkg.sv =====
// ----------------------------------------------------------------------------
// smalu_pkg
// Shared types and codes for the sign-magnitude ALU: transaction structs,
// operation, status and order codes, sequencer state and control struct.
// ----------------------------------------------------------------------------
package smalu_pkg;

	localparam int WIDTH = 32;
	localparam int CNT_W = $clog2(WIDTH);
	localparam int NB_W  = $clog2(WIDTH + 1);

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] OP_CMP = 3'd4;

	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_OVF = 2'd1;
	localparam logic [1:0] ST_DBZ = 2'd2;

	localparam logic [1:0] ORD_EQ = 2'd0;
	localparam logic [1:0] ORD_LT = 2'd1;
	localparam logic [1:0] ORD_GT = 2'd2;

	typedef struct packed {
		logic [2:0]       req_type;
		logic             a_neg;
		logic [WIDTH-1:0] a_mag;
		logic             b_neg;
		logic [WIDTH-1:0] b_mag;
	} req_t;

	typedef struct packed {
		logic             res_neg;
		logic [WIDTH-1:0] res_mag;
		logic [1:0]       status;
		logic [1:0]       order;
	} rsp_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic busy;
		logic load;
		logic step;
		logic strobe;
	} ctrl_t;

endpackage

// ===== design/smalu_addsub.sv =====
// ----------------------------------------------------------------------------
// smalu_addsub
// Shared adder/subtractor. The top bit of r is the borrow of a subtraction,
// bit WIDTH is the carry of an addition.
// ----------------------------------------------------------------------------
module smalu_addsub
	import smalu_pkg::*;
(
	input  logic [WIDTH:0]   x,
	input  logic [WIDTH-1:0] y,
	input  logic             sub,
	output logic [WIDTH+1:0] r
);

	always_comb begin
		if (sub) begin
			r = {1'b0, x} - {2'b00, y};
		end else begin
			r = {1'b0, x} + {2'b00, y};
		end
	end

endmodule

// ===== design/smalu_seq.sv =====
// ----------------------------------------------------------------------------
// smalu_seq
// Sequencer: loads a transaction, steps the shared unit until the datapath
// reports the last step, then presents the result for one cycle.
// ----------------------------------------------------------------------------
module smalu_seq
	import smalu_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             iter_done,
	output ctrl_t            ctrl,
	output logic [CNT_W-1:0] cnt
);

	state_t           state_q;
	state_t           state_nx;
	logic [CNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (ctrl.load) begin
				cnt_q <= '0;
			end else if (ctrl.step) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_nx = S_RUN;
				end
			end
			S_RUN: begin
				if (iter_done) begin
					state_nx = S_DONE;
				end
			end
			S_DONE: begin
				state_nx = S_IDLE;
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_comb begin
		ctrl = '0;
		unique case (state_q)
			S_IDLE: begin
				ctrl.load = start;
			end
			S_RUN: begin
				ctrl.busy = 1'b1;
				ctrl.step = 1'b1;
			end
			S_DONE: begin
				ctrl.busy   = 1'b1;
				ctrl.strobe = 1'b1;
			end
			default: begin
				ctrl = '0;
			end
		endcase
	end

	assign cnt = cnt_q;

endmodule

// ===== design/sign_magnitude_alu_unit.sv =====
// ----------------------------------------------------------------------------
// sign_magnitude_alu_unit
// Sign-magnitude add, subtract, multiply, divide and compare on one shared
// adder/subtractor stepped by a small sequencer.
// ----------------------------------------------------------------------------
//  channel   ports               handshake
//  request   start, busy, req    taken when start is high and busy is low
//  result    done, rsp           done high for one cycle, no back-pressure
//
//  Add, subtract, compare, divide by zero and unknown codes use one step;
//  add or subtract with unlike effective signs takes a second subtraction
//  when b is the larger magnitude.
//  Multiply and nonzero divide step once per magnitude bit.
//  busy stays high from acceptance through the done cycle.
//  Reset returns the sequencer to idle; no transaction is in flight after it.
// ----------------------------------------------------------------------------
module sign_magnitude_alu_unit
	import smalu_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	ctrl_t            ctrl;
	logic [CNT_W-1:0] cnt;
	logic             iter_done;

	logic [2:0]       op_q;
	logic             an_q;
	logic             bn_q;
	logic [WIDTH-1:0] hi_q;
	logic [WIDTH-1:0] lo_q;
	logic [WIDTH-1:0] b_q;
	logic [WIDTH-1:0] ca_q;
	logic [WIDTH-1:0] cb_q;
	logic [NB_W-1:0]  na_q;
	logic [NB_W-1:0]  nb_q;
	rsp_t             rsp_q;

	logic [WIDTH:0]   x;
	logic [WIDTH-1:0] y;
	logic             sub;
	logic [WIDTH+1:0] r;
	logic             borrow;
	logic [WIDTH:0]   msum;
	logic [NB_W-1:0]  na_nx;
	logic [NB_W-1:0]  nb_nx;
	logic             sa;
	logic             sb;
	rsp_t             rsp_nx;

	smalu_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.iter_done (iter_done),
		.ctrl      (ctrl),
		.cnt       (cnt)
	);

	smalu_addsub u_addsub (
		.x   (x),
		.y   (y),
		.sub (sub),
		.r   (r)
	);

	always_comb begin
		x   = {1'b0, lo_q};
		y   = b_q;
		sub = 1'b0;
		case (op_q) inside
			OP_ADD, OP_SUB: begin
				if (an_q != bn_q) begin
					sub = 1'b1;
					if (cnt != '0) begin
						x = {1'b0, b_q};
						y = lo_q;
					end
				end
			end
			OP_MUL: begin
				x = {1'b0, hi_q};
			end
			OP_DIV: begin
				x   = {hi_q, lo_q[WIDTH-1]};
				sub = 1'b1;
			end
			OP_CMP: begin
				sub = 1'b1;
			end
			default: begin
				sub = 1'b0;
			end
		endcase
	end

	assign borrow = r[WIDTH+1];
	assign msum   = lo_q[0] ? r[WIDTH:0] : {1'b0, hi_q};
	assign na_nx  = na_q + NB_W'(ca_q != '0);
	assign nb_nx  = nb_q + NB_W'(cb_q != '0);
	assign sa     = an_q && (lo_q != '0);
	assign sb     = bn_q && (b_q != '0);

	always_comb begin
		case (op_q) inside
			OP_ADD, OP_SUB: iter_done = (an_q == bn_q) || (cnt != '0) || !borrow;
			OP_MUL:         iter_done = (cnt == CNT_W'(WIDTH - 1));
			OP_DIV:         iter_done = (b_q == '0) || (cnt == CNT_W'(WIDTH - 1));
			default:        iter_done = 1'b1;
		endcase
	end

	always_comb begin
		rsp_nx = '0;
		case (op_q) inside
			OP_ADD, OP_SUB: begin
				if (an_q == bn_q) begin
					rsp_nx.res_neg = an_q;
					if (r[WIDTH]) begin
						rsp_nx.res_mag = lo_q;
						rsp_nx.status  = ST_OVF;
					end else begin
						rsp_nx.res_mag = r[WIDTH-1:0];
					end
				end else begin
					rsp_nx.res_neg = (cnt == '0) ? an_q : bn_q;
					rsp_nx.res_mag = r[WIDTH-1:0];
				end
			end
			OP_MUL: begin
				if (({1'b0, na_nx} + {1'b0, nb_nx}) > (NB_W + 1)'(WIDTH)) begin
					rsp_nx.status = ST_OVF;
				end else begin
					rsp_nx.res_neg = an_q ^ bn_q;
					rsp_nx.res_mag = {msum[0], lo_q[WIDTH-1:1]};
				end
			end
			OP_DIV: begin
				if (b_q == '0) begin
					rsp_nx.status = ST_DBZ;
				end else begin
					rsp_nx.res_neg = an_q ^ bn_q;
					rsp_nx.res_mag = {lo_q[WIDTH-2:0], ~borrow};
				end
			end
			OP_CMP: begin
				if (sa != sb) begin
					rsp_nx.order = sa ? ORD_LT : ORD_GT;
				end else if (!borrow && (r[WIDTH-1:0] == '0)) begin
					rsp_nx.order = ORD_EQ;
				end else if (borrow != sa) begin
					rsp_nx.order = ORD_LT;
				end else begin
					rsp_nx.order = ORD_GT;
				end
			end
			default: begin
				rsp_nx = '0;
			end
		endcase
		if (rsp_nx.res_mag == '0) begin
			rsp_nx.res_neg = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			op_q <= req.req_type;
			an_q <= req.a_neg;
			bn_q <= req.b_neg ^ (req.req_type == OP_SUB);
			hi_q <= '0;
			lo_q <= req.a_mag;
			b_q  <= req.b_mag;
			ca_q <= req.a_mag;
			cb_q <= req.b_mag;
			na_q <= '0;
			nb_q <= '0;
		end else if (ctrl.step) begin
			case (op_q) inside
				OP_MUL: begin
					hi_q <= msum[WIDTH:1];
					lo_q <= {msum[0], lo_q[WIDTH-1:1]};
					ca_q <= ca_q >> 1;
					cb_q <= cb_q >> 1;
					na_q <= na_nx;
					nb_q <= nb_nx;
				end
				OP_DIV: begin
					hi_q <= borrow ? x[WIDTH-1:0] : r[WIDTH-1:0];
					lo_q <= {lo_q[WIDTH-2:0], ~borrow};
				end
				default: begin
					hi_q <= hi_q;
				end
			endcase
		end
		if (ctrl.step && iter_done) begin
			rsp_q <= rsp_nx;
		end
	end

	assign busy = ctrl.busy;
	assign done = ctrl.strobe;
	assign rsp  = rsp_q;

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe outside a transaction");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not raise busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held longer than one cycle");

	a_zero_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (rsp.res_mag == '0)) |-> !rsp.res_neg)
		else $error("zero result carries a negative sign");

endmodule

// ===== sim/sign_magnitude_alu_unit_tb.sv =====
// ----------------------------------------------------------------------------
// sign_magnitude_alu_unit_tb
// Self-checking bench for the sign-magnitude ALU. A driver feeds queued
// transactions through the start/busy handshake with random idle cycles, a
// bit-accurate predictor computes each expected result at acceptance, and a
// monitor compares every done strobe field by field against the oldest one.
// Directed corner cases come first, then randomized operands and operations.
// ----------------------------------------------------------------------------
module sign_magnitude_alu_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import smalu_pkg::*;

	localparam logic [WIDTH-1:0] MAG_MAX    = '1;
	localparam logic [2:0]       OP_RSVD_LO = 3'd5;
	localparam logic [2:0]       OP_RSVD_HI = 3'd7;
	localparam int               N_RANDOM   = 1950;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	req_t req    = '0;
	logic busy;
	logic done;
	rsp_t rsp;

	req_t req_backlog[$];
	rsp_t results_due[$];
	int   n_taken  = 0;
	int   n_errors = 0;

	sign_magnitude_alu_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	always #5 clk = ~clk;

	function automatic int bit_len(logic [WIDTH-1:0] v);
		int n;
		n = 0;
		for (int i = 0; i < WIDTH; i++)
			if (v[i]) n = i + 1;
		return n;
	endfunction

	function automatic rsp_t signed_sum(logic an, logic [WIDTH-1:0] am,
					    logic bn, logic [WIDTH-1:0] bm);
		rsp_t r;
		logic [WIDTH:0] s;
		r = '0;
		if (an == bn) begin
			s = {1'b0, am} + {1'b0, bm};
			r.res_neg = an;
			if (s[WIDTH]) begin
				r.status  = ST_OVF;
				r.res_mag = am;
			end else begin
				r.res_mag = s[WIDTH-1:0];
			end
		end else if (am > bm) begin
			r.res_neg = an;
			r.res_mag = am - bm;
		end else begin
			r.res_neg = bn;
			r.res_mag = bm - am;
		end
		return r;
	endfunction

	function automatic rsp_t alu_predict(req_t q);
		rsp_t r;
		logic [2*WIDTH-1:0] prod;
		logic sa, sb;
		r = '0;
		case (q.req_type)
			OP_ADD: r = signed_sum(q.a_neg, q.a_mag, q.b_neg, q.b_mag);
			OP_SUB: r = signed_sum(q.a_neg, q.a_mag, !q.b_neg, q.b_mag);
			OP_MUL: begin
				if (bit_len(q.a_mag) + bit_len(q.b_mag) > WIDTH) begin
					r.status = ST_OVF;
				end else begin
					prod      = q.a_mag * q.b_mag;
					r.res_mag = prod[WIDTH-1:0];
					r.res_neg = q.a_neg ^ q.b_neg;
				end
			end
			OP_DIV: begin
				if (q.b_mag == '0) begin
					r.status = ST_DBZ;
				end else begin
					r.res_mag = q.a_mag / q.b_mag;
					r.res_neg = q.a_neg ^ q.b_neg;
				end
			end
			OP_CMP: begin
				sa = q.a_neg && (q.a_mag != '0);
				sb = q.b_neg && (q.b_mag != '0);
				if (sa != sb)
					r.order = sa ? ORD_LT : ORD_GT;
				else if (q.a_mag == q.b_mag)
					r.order = ORD_EQ;
				else if ((q.a_mag < q.b_mag) != sa)
					r.order = ORD_LT;
				else
					r.order = ORD_GT;
			end
			default: ;
		endcase
		if (r.res_mag == '0) r.res_neg = 1'b0;
		return r;
	endfunction

	function automatic logic [WIDTH-1:0] rand_mag();
		case ($urandom_range(7))
			0: return '0;
			1: return MAG_MAX;
			2: return WIDTH'(1) << $urandom_range(WIDTH - 1);
			default: return WIDTH'({$urandom, $urandom}) >> $urandom_range(WIDTH - 1);
		endcase
	endfunction

	task automatic queue_op(logic [2:0] op, logic an, logic [WIDTH-1:0] am,
				logic bn, logic [WIDTH-1:0] bm);
		req_t q;
		q.req_type = op;
		q.a_neg    = an;
		q.a_mag    = am;
		q.b_neg    = bn;
		q.b_mag    = bm;
		req_backlog.insert(req_backlog.size(), q);
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (req_backlog.size() != 0 || start || results_due.size() != 0);
	endtask

	task automatic check_field(string name, logic [WIDTH-1:0] want,
				   logic [WIDTH-1:0] got);
		if (want !== got) begin
			n_errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h",
				 $time, name, want, got);
		end
	endtask

	// hold req while busy; advance to the next transaction once taken
	always @(posedge clk or negedge arst_n) begin : driver
		bit idle;
		if (!arst_n) begin
			start <= 1'b0;
			req   <= '0;
		end else begin
			if (start && !busy) begin
				results_due.insert(results_due.size(), alu_predict(req));
				n_taken++;
			end
			if (!start || !busy) begin
				idle = !(n_taken >= 700 && n_taken < 1000) && ($urandom_range(99) < 25);
				if (req_backlog.size() != 0 && !idle) begin
					req   <= req_backlog.pop_front();
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : monitor
		rsp_t want;
		if (arst_n && done) begin
			if (results_due.size() == 0) begin
				n_errors++;
				$display("%0t: unexpected result, expected none, actual %0h",
					 $time, rsp);
			end else begin
				want = results_due.pop_front();
				check_field("res_neg", want.res_neg, rsp.res_neg);
				check_field("res_mag", want.res_mag, rsp.res_mag);
				check_field("status", want.status, rsp.status);
				check_field("order", want.order, rsp.order);
			end
		end
	end

	initial begin : stimulus
		logic [WIDTH-1:0] a, b;
		logic [2:0] op;
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		queue_op(OP_ADD, 1'b0, MAG_MAX, 1'b0, 1);
		queue_op(OP_ADD, 1'b1, MAG_MAX, 1'b1, MAG_MAX);
		queue_op(OP_ADD, 1'b0, 0, 1'b0, 0);
		queue_op(OP_ADD, 1'b1, 1234, 1'b0, 1234);
		queue_op(OP_ADD, 1'b0, 5, 1'b1, 9);
		queue_op(OP_ADD, 1'b1, MAG_MAX, 1'b0, 1);
		queue_op(OP_SUB, 1'b0, MAG_MAX, 1'b1, 1);
		queue_op(OP_SUB, 1'b1, 7, 1'b1, 7);
		queue_op(OP_SUB, 1'b0, 0, 1'b0, MAG_MAX);
		queue_op(OP_MUL, 1'b0, MAG_MAX, 1'b0, 2);
		queue_op(OP_MUL, 1'b1, 'hFFFF, 1'b0, 'hFFFF);
		queue_op(OP_MUL, 1'b0, MAG_MAX ^ (MAG_MAX >> 1), 1'b0, 1);
		queue_op(OP_MUL, 1'b1, 0, 1'b0, MAG_MAX);
		queue_op(OP_MUL, 1'b1, 1, 1'b1, 1);
		queue_op(OP_DIV, 1'b1, 100, 1'b0, 0);
		queue_op(OP_DIV, 1'b1, 100, 1'b0, 7);
		queue_op(OP_DIV, 1'b0, MAG_MAX, 1'b1, 1);
		queue_op(OP_DIV, 1'b1, 3, 1'b0, MAG_MAX);
		queue_op(OP_CMP, 1'b1, 0, 1'b0, 0);
		queue_op(OP_CMP, 1'b1, 5, 1'b0, 0);
		queue_op(OP_CMP, 1'b1, 3, 1'b1, 9);
		queue_op(OP_CMP, 1'b0, MAG_MAX, 1'b0, MAG_MAX);
		queue_op(OP_CMP, 1'b0, 1, 1'b1, MAG_MAX);
		queue_op(OP_RSVD_LO, 1'b1, MAG_MAX, 1'b1, MAG_MAX);
		queue_op(OP_RSVD_HI, 1'b0, 1, 1'b0, 1);
		wait_drained();

		for (int i = 0; i < N_RANDOM; i++) begin
			if ($urandom_range(19) == 0)
				op = 3'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
			else
				op = 3'($urandom_range(OP_ADD, OP_CMP));
			a = rand_mag();
			case ($urandom_range(9))
				0: b = a;
				1: b = MAG_MAX - a;
				2: b = MAG_MAX - a + 1'b1;
				default: b = rand_mag();
			endcase
			queue_op(op, 1'($urandom_range(1)), a, 1'($urandom_range(1)), b);
			if (i == N_RANDOM / 2) wait_drained();
		end

		wait_drained();
		repeat (WIDTH + 4) @(posedge clk);
		if (n_errors == 0)
			$display("sign_magnitude_alu_unit_tb: clean");
		else
			$display("sign_magnitude_alu_unit_tb: errors");
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("sign_magnitude_alu_unit_tb: errors");
		$finish;
	end

endmodule

// ===== sim.f =====
design/smalu_pkg.sv
design/smalu_addsub.sv
design/smalu_seq.sv
design/sign_magnitude_alu_unit.sv
sim/sign_magnitude_alu_unit_tb.sv
